// ===== hw/rtl/bre_pkg.sv =====
// Shared types and constants for the byte run/literal encoder.
// Used by bre_front, bre_cmd_fifo, bre_back and byte_rle_encoder.
package bre_pkg;

	// run limits and header flag
	localparam logic [7:0] RUN_MIN  = 8'd3;
	localparam logic [7:0] RUN_MAX  = 8'd130;
	localparam logic [7:0] RUN_FLAG = 8'h80;

	// command queue between front and back
	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_AW    = 2;

	typedef enum logic [1:0] {
		CMD_PUSH,    // append val to the open literal
		CMD_RUN,     // emit hdr then val
		CMD_FLUSH,   // close the open literal, if any
		CMD_FINISH   // close literal, then send the final word
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] hdr;
		logic [7:0] val;
	} cmd_t;

	// run header byte for a run of len bytes
	function automatic logic [7:0] run_hdr(input logic [7:0] len);
		logic [7:0] d;
		d = len - RUN_MIN;
		return RUN_FLAG | {1'b0, d[6:0]};
	endfunction

endpackage

// ===== hw/rtl/bre_front.sv =====
// Front end: accepts raw bytes, tracks the pending run and issues commands.
// Depends on bre_pkg.
module bre_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    in_byte,
	input  logic          in_last,
	output logic          cmd_push,
	output bre_pkg::cmd_t cmd_data,
	input  logic          cmd_full
);
	import bre_pkg::*;

	localparam logic [1:0] FS_IDLE = 2'd0;
	localparam logic [1:0] FS_STEP = 2'd1;
	localparam logic [1:0] FS_TAIL = 2'd2;

	logic [1:0] state_q, state_d;
	logic [7:0] cur_byte_q;
	logic       cur_last_q;
	logic [7:0] run_val_q, run_val_d;
	logic [7:0] run_len_q, run_len_d;
	logic [7:0] len_inc;
	logic       emit;

	assign in_ready = (state_q == FS_IDLE);
	assign len_inc  = run_len_q + 8'd1;
	assign emit     = (len_inc == RUN_MIN) || (len_inc == RUN_MAX);

	always_comb begin
		state_d   = state_q;
		run_val_d = run_val_q;
		run_len_d = run_len_q;
		cmd_push  = 1'b0;
		cmd_data  = '{kind: CMD_PUSH, hdr: run_hdr(run_len_q), val: run_val_q};
		unique case (state_q)
			FS_IDLE: begin
				if (in_valid) begin
					state_d = FS_STEP;
				end
			end
			FS_STEP: begin
				if (run_len_q != 8'd0 && cur_byte_q == run_val_q && run_len_q < RUN_MAX) begin
					// run grows; third byte closes the literal, the last one sends the run
					cmd_data.kind = (len_inc == RUN_MIN) ? CMD_FLUSH : CMD_RUN;
					cmd_data.hdr  = run_hdr(len_inc);
					if (!emit || !cmd_full) begin
						cmd_push  = emit;
						run_len_d = (len_inc == RUN_MAX) ? 8'd0 : len_inc;
						state_d   = cur_last_q ? FS_TAIL : FS_IDLE;
					end
				end else if (run_len_q >= RUN_MIN) begin
					cmd_data.kind = CMD_RUN;
					if (!cmd_full) begin
						cmd_push  = 1'b1;
						run_len_d = 8'd0;
					end
				end else if (run_len_q != 8'd0) begin
					// short pending run spills into the literal, one byte a cycle while the queue has room
					if (!cmd_full) begin
						cmd_push  = 1'b1;
						run_len_d = run_len_q - 8'd1;
					end
				end else begin
					run_val_d = cur_byte_q;
					run_len_d = 8'd1;
					state_d   = cur_last_q ? FS_TAIL : FS_IDLE;
				end
			end
			FS_TAIL: begin
				if (run_len_q >= RUN_MIN) begin
					cmd_data.kind = CMD_RUN;
					if (!cmd_full) begin
						cmd_push  = 1'b1;
						run_len_d = 8'd0;
					end
				end else if (run_len_q != 8'd0) begin
					if (!cmd_full) begin
						cmd_push  = 1'b1;
						run_len_d = run_len_q - 8'd1;
					end
				end else begin
					cmd_data.kind = CMD_FINISH;
					if (!cmd_full) begin
						cmd_push = 1'b1;
						state_d  = FS_IDLE;
					end
				end
			end
			default: begin
				state_d = FS_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= FS_IDLE;
			run_val_q <= 8'd0;
			run_len_q <= 8'd0;
		end else begin
			state_q   <= state_d;
			run_val_q <= run_val_d;
			run_len_q <= run_len_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cur_byte_q <= in_byte;
			cur_last_q <= in_last;
		end
	end

endmodule

// ===== hw/rtl/bre_cmd_fifo.sv =====
// Short command queue between the front end and the back end.
// Depends on bre_pkg.
module bre_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bre_pkg::cmd_t push_data,
	output logic          full,
	input  logic          pop,
	output bre_pkg::cmd_t head,
	output logic          empty
);
	import bre_pkg::*;

	cmd_t                entry_q [CMDQ_DEPTH];
	logic [CMDQ_AW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CMDQ_AW:0]    count_q;
	logic                do_push, do_pop;

	assign full    = (count_q == (CMDQ_AW+1)'(CMDQ_DEPTH));
	assign empty   = (count_q == '0);
	assign head    = entry_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + CMDQ_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + CMDQ_AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (CMDQ_AW+1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (CMDQ_AW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== hw/rtl/bre_back.sv =====
// Back end: runs commands, holds the literal store, packs bytes into words.
// Depends on bre_pkg.
module bre_back #(
	parameter int LITERAL_MAX = 128,
	parameter int WORD_BYTES  = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  bre_pkg::cmd_t cmd,
	output logic          cmd_pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [63:0]   out_word,
	output logic [3:0]    out_count,
	output logic          out_end
);
	import bre_pkg::*;

	localparam int         LIT_AW   = (LITERAL_MAX > 1) ? $clog2(LITERAL_MAX) : 1;
	localparam logic [7:0] LIT_MAX8 = 8'(LITERAL_MAX);
	localparam logic [3:0] WB       = 4'(WORD_BYTES);

	localparam logic [2:0] BS_CMD    = 3'd0;
	localparam logic [2:0] BS_RUNVAL = 3'd1;
	localparam logic [2:0] BS_LHDR   = 3'd2;
	localparam logic [2:0] BS_LBODY  = 3'd3;
	localparam logic [2:0] BS_FINAL  = 3'd4;

	logic [2:0]        bstate_q, bstate_d;
	logic [7:0]        lit_len_q, lit_len_d;
	logic [LIT_AW-1:0] idx_q, idx_d;
	logic              fin_q, fin_d;

	logic [7:0]        store_mem [LITERAL_MAX];
	logic [7:0]        rd_data_q;
	logic              wr_en, rd_en;
	logic [LIT_AW-1:0] rd_addr;

	logic [63:0]       acc_q;
	logic [3:0]        acc_cnt_q;
	logic              out_valid_q, out_end_q;
	logic [63:0]       out_word_q;
	logic [3:0]        out_count_q;

	logic              out_free, acc_full, can_put;
	logic              put_en, put_fire, final_fire;
	logic [7:0]        put_byte;

	assign out_free  = !out_valid_q || out_ready;
	assign acc_full  = (acc_cnt_q == WB);
	assign can_put   = !acc_full || out_free;
	assign put_fire  = put_en && can_put;

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;
	assign out_count = out_count_q;
	assign out_end   = out_end_q;

	always_comb begin
		bstate_d   = bstate_q;
		lit_len_d  = lit_len_q;
		idx_d      = idx_q;
		fin_d      = fin_q;
		cmd_pop    = 1'b0;
		wr_en      = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = '0;
		put_en     = 1'b0;
		put_byte   = cmd.hdr;
		final_fire = 1'b0;
		unique case (bstate_q)
			BS_CMD: begin
				if (cmd_valid) begin
					case (cmd.kind)
						CMD_PUSH: begin
							wr_en     = 1'b1;
							cmd_pop   = 1'b1;
							lit_len_d = lit_len_q + 8'd1;
							if (lit_len_q + 8'd1 == LIT_MAX8) begin
								fin_d    = 1'b0;
								bstate_d = BS_LHDR;
							end
						end
						CMD_RUN: begin
							put_en = 1'b1;
							if (can_put) begin
								bstate_d = BS_RUNVAL;
							end
						end
						CMD_FLUSH: begin
							cmd_pop = 1'b1;
							fin_d   = 1'b0;
							if (lit_len_q != 8'd0) begin
								bstate_d = BS_LHDR;
							end
						end
						default: begin
							cmd_pop  = 1'b1;
							fin_d    = 1'b1;
							bstate_d = (lit_len_q != 8'd0) ? BS_LHDR : BS_FINAL;
						end
					endcase
				end
			end
			BS_RUNVAL: begin
				put_en   = 1'b1;
				put_byte = cmd.val;
				if (can_put) begin
					cmd_pop  = 1'b1;
					bstate_d = BS_CMD;
				end
			end
			BS_LHDR: begin
				put_en   = 1'b1;
				put_byte = lit_len_q - 8'd1;
				if (can_put) begin
					rd_en    = 1'b1;
					idx_d    = '0;
					bstate_d = BS_LBODY;
				end
			end
			BS_LBODY: begin
				put_en   = 1'b1;
				put_byte = rd_data_q;
				rd_addr  = idx_q + LIT_AW'(1);
				if (can_put) begin
					if (8'(idx_q) + 8'd1 == lit_len_q) begin
						lit_len_d = 8'd0;
						bstate_d  = fin_q ? BS_FINAL : BS_CMD;
					end else begin
						rd_en = 1'b1;
						idx_d = idx_q + LIT_AW'(1);
					end
				end
			end
			BS_FINAL: begin
				if (acc_cnt_q == 4'd0) begin
					bstate_d = BS_CMD;
				end else if (out_free) begin
					final_fire = 1'b1;
					bstate_d   = BS_CMD;
				end
			end
			default: begin
				bstate_d = BS_CMD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bstate_q    <= BS_CMD;
			lit_len_q   <= 8'd0;
			idx_q       <= '0;
			fin_q       <= 1'b0;
			acc_q       <= 64'd0;
			acc_cnt_q   <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			bstate_q  <= bstate_d;
			lit_len_q <= lit_len_d;
			idx_q     <= idx_d;
			fin_q     <= fin_d;
			if (put_fire) begin
				if (acc_full) begin
					acc_q     <= {56'd0, put_byte};
					acc_cnt_q <= 4'd1;
				end else begin
					acc_q[8*acc_cnt_q[2:0] +: 8] <= put_byte;
					acc_cnt_q <= acc_cnt_q + 4'd1;
				end
			end else if (final_fire) begin
				acc_q     <= 64'd0;
				acc_cnt_q <= 4'd0;
			end
			if ((put_fire && acc_full) || final_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((put_fire && acc_full) || final_fire) begin
			out_word_q  <= acc_q;
			out_count_q <= acc_cnt_q;
			out_end_q   <= final_fire;
		end
	end

	// literal store, one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_mem[lit_len_q[LIT_AW-1:0]] <= cmd.val;
		end
		if (rd_en) begin
			rd_data_q <= store_mem[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/byte_rle_encoder.sv =====
// Byte run/literal encoder (PackBits-style): raw bytes in, 8-byte words out.
// Top level; instantiates bre_front, bre_cmd_fifo and bre_back; uses bre_pkg.
//  - s_axis: one raw byte per transaction, tlast on the final byte of a frame.
//  - m_axis: encoded stream in words of WORD_BYTES bytes, first byte in bits 7:0,
//    tuser = number of valid bytes, tlast on the final word of the frame.
//    Unused upper bytes are zero.
//  - Runs of 3..130 equal bytes become {0x80|(n-3), value}; other bytes form
//    literals of up to LITERAL_MAX bytes sent as {n-1, bytes...}.
//  - Input side: the front end accepts a byte, then classifies it in FS_STEP and
//    takes no new byte meanwhile; a byte that breaks a pending run or ends a
//    frame first issues its commands, each held while the queue is full.
//  - Output side: the back end puts one encoded byte per cycle into the word
//    packer unless it is stalled; a literal flush of n bytes puts the header
//    n-1, then the bytes read from the literal store, one per cycle.
//    A 4-entry command queue decouples the two. A full word goes out the cycle
//    after the next encoded byte enters the packer; the flagged last word is
//    registered in BS_FINAL, after the finish command and any literal flush.
//  - Reset (arst_n low): run, literal and packer state cleared, queue empty.
//  - Receiver stall: one output word waits in a register; when another word
//    completes the back end stops, the queue fills and s_axis_tready drops.
module byte_rle_encoder #(
	parameter int LITERAL_MAX = 128,
	parameter int WORD_BYTES  = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tlast,   // frame_end
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // [63:0] packed_word
	output logic [3:0]  m_axis_tuser,   // [3:0] byte_count
	output logic        m_axis_tlast    // stream_end
);
	import bre_pkg::*;

	logic cmd_push, cmd_full, cmd_pop, cmd_empty;
	cmd_t cmd_in, cmd_head;

	// front end: run tracking, at most one command per cycle, held while the queue is full
	bre_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.in_last  (s_axis_tlast),
		.cmd_push (cmd_push),
		.cmd_data (cmd_in),
		.cmd_full (cmd_full)
	);

	bre_cmd_fifo u_cmdq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_push),
		.push_data (cmd_in),
		.full      (cmd_full),
		.pop       (cmd_pop),
		.head      (cmd_head),
		.empty     (cmd_empty)
	);

	// back end: literal store and word packer
	bre_back #(
		.LITERAL_MAX (LITERAL_MAX),
		.WORD_BYTES  (WORD_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (!cmd_empty),
		.cmd       (cmd_head),
		.cmd_pop   (cmd_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_word  (m_axis_tdata),
		.out_count (m_axis_tuser),
		.out_end   (m_axis_tlast)
	);

`ifndef SYNTHESIS
	// front never pushes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> !cmd_full)
		else $error("command queue overflow");

	// back never pops an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> !cmd_empty)
		else $error("command queue underflow");

	// every word carries 1..WORD_BYTES bytes
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser != 4'd0) && (m_axis_tuser <= 4'(WORD_BYTES)))
		else $error("byte count out of range");
`endif

endmodule

// ===== test/byte_rle_encoder_tb.sv =====
// Self-checking testbench for byte_rle_encoder: frames of raw bytes go in,
// 8-byte encoded words come out and are checked against an in-bench encoder.
// Depends on bre_pkg (run constants) and the byte_rle_encoder RTL.
module byte_rle_encoder_tb;
	import bre_pkg::*;

	localparam int LITERAL_MAX = 128;
	localparam int WORD_BYTES  = 8;
	localparam int HOLD_CYCLES = 700;     // long receiver hold-off
	localparam int RANDOM_ITEMS = 24;

	typedef struct packed {
		logic [63:0] word;
		logic [3:0]  count;
		logic        last;
	} enc_word_t;

	// directed row: known = 1 means the single result of this row is typed in
	typedef struct packed {
		logic [7:0]  data;
		logic        eof;
		logic        known;
		logic [63:0] word;
		logic [3:0]  count;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;
	logic [3:0]  m_axis_tuser;
	logic        m_axis_tlast;

	byte_rle_encoder #(
		.LITERAL_MAX(LITERAL_MAX),
		.WORD_BYTES (WORD_BYTES)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 0;
	end

	int          errors = 0;
	bit          idle_on = 1'b0;
	bit          hold_start = 1'b0;
	enc_word_t   pending_words[$];
	logic [7:0]  frame_q[$];

	// encoder state mirrored by the bench
	logic [7:0]  lit_buf[LITERAL_MAX];
	int unsigned lit_len = 0;
	logic [7:0]  run_byte = 8'h00;
	int unsigned run_len = 0;
	logic [63:0] acc_word = 64'h0;
	int unsigned acc_cnt = 0;

	// a full word is only sent once another byte shows up
	function automatic void pack_byte(input logic [7:0] b);
		if (acc_cnt >= WORD_BYTES) begin
			pending_words.push_back('{acc_word, 4'(acc_cnt), 1'b0});
			acc_word = 64'h0;
			acc_cnt = 0;
		end
		acc_word[8*acc_cnt +: 8] = b;
		acc_cnt++;
	endfunction

	function automatic void close_literal();
		if (lit_len == 0)
			return;
		pack_byte(8'(lit_len - 1) & 8'h7F);
		for (int i = 0; i < lit_len; i++)
			pack_byte(lit_buf[i]);
		lit_len = 0;
	endfunction

	function automatic void add_literal(input logic [7:0] b);
		lit_buf[lit_len] = b;
		lit_len++;
		if (lit_len >= LITERAL_MAX)
			close_literal();
	endfunction

	function automatic void close_run();
		pack_byte(RUN_FLAG | (8'(run_len - RUN_MIN) & 8'h7F));
		pack_byte(run_byte);
		run_len = 0;
	endfunction

	// pending bytes: a run of 3+ goes out, one or two bytes join the literal
	function automatic void settle_run();
		if (run_len >= RUN_MIN) begin
			close_run();
		end else begin
			while (run_len > 0) begin
				add_literal(run_byte);
				run_len--;
			end
		end
	endfunction

	function automatic void rle_predict_byte(input logic [7:0] b, input logic eof);
		if (run_len > 0 && b == run_byte && run_len < RUN_MAX) begin
			run_len++;
			if (run_len == RUN_MIN)
				close_literal();
			if (run_len >= RUN_MAX)
				close_run();
		end else begin
			settle_run();
			run_byte = b;
			run_len = 1;
		end
		if (eof) begin
			settle_run();
			close_literal();
			if (acc_cnt > 0)
				pending_words.push_back('{acc_word, 4'(acc_cnt), 1'b1});
			acc_word = 64'h0;
			acc_cnt = 0;
		end
	endfunction

	// directed part: extremes, short runs, pairs, run after literal, full final word
	dir_row_t dir_rows[23] = '{
		'{8'h00, 1'b1, 1'b1, 64'h0000, 4'd2},        // single 0x00 -> literal of 1
		'{8'hFF, 1'b1, 1'b1, 64'hFF00, 4'd2},        // single 0xFF
		'{8'hAB, 1'b0, 1'b0, 64'h0, 4'd0},
		'{8'hAB, 1'b0, 1'b0, 64'h0, 4'd0},
		'{8'hAB, 1'b1, 1'b1, 64'hAB80, 4'd2},        // shortest run
		'{8'h55, 1'b0, 1'b0, 64'h0, 4'd0},
		'{8'h55, 1'b1, 1'b1, 64'h0055_5501, 4'd3},   // pending pair at frame end
		'{8'h01, 1'b0, 1'b0, 64'h0, 4'd0},
		'{8'h02, 1'b0, 1'b0, 64'h0, 4'd0},
		'{8'h07, 1'b0, 1'b0, 64'h0, 4'd0},
		'{8'h07, 1'b0, 1'b0, 64'h0, 4'd0},
		'{8'h07, 1'b0, 1'b0, 64'h0, 4'd0},           // run closes the literal
		'{8'h03, 1'b1, 1'b0, 64'h0, 4'd0},
		'{8'h80, 1'b0, 1'b0, 64'h0, 4'd0},           // 7-byte literal -> one full word
		'{8'h7F, 1'b0, 1'b0, 64'h0, 4'd0},
		'{8'h01, 1'b0, 1'b0, 64'h0, 4'd0},
		'{8'hFE, 1'b0, 1'b0, 64'h0, 4'd0},
		'{8'h10, 1'b0, 1'b0, 64'h0, 4'd0},
		'{8'hEF, 1'b0, 1'b0, 64'h0, 4'd0},
		'{8'h20, 1'b1, 1'b0, 64'h0, 4'd0},
		'{8'hCC, 1'b0, 1'b0, 64'h0, 4'd0},           // pair broken by a new byte
		'{8'hCC, 1'b0, 1'b0, 64'h0, 4'd0},
		'{8'h0D, 1'b1, 1'b0, 64'h0, 4'd0}
	};

	// offer one byte, wait for the transaction, then record what it should produce
	task automatic send_item(input logic [7:0] b, input logic eof, input logic known,
			input logic [63:0] kword, input logic [3:0] kcount);
		int mark;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= eof;
		do
			@(posedge clk);
		while (!s_axis_tready);
		mark = pending_words.size();
		rle_predict_byte(b, eof);
		if (known) begin
			while (pending_words.size() > mark)
				void'(pending_words.pop_back());
			pending_words.push_back('{kword, kcount, eof});
		end
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_q.size(); i++)
			send_item(frame_q[i], i == frame_q.size() - 1, 1'b0, 64'h0, 4'd0);
	endtask

	// mostly well-formed runs and literals, some raw noise
	task automatic build_random_frame();
		int         nseg;
		int         len;
		logic [7:0] v;
		frame_q.delete();
		nseg = $urandom_range(1, 6);
		repeat (nseg) begin
			v = 8'($urandom);
			case ($urandom_range(0, 3))
				0: begin
					len = $urandom_range(1, 6);
					repeat (len) frame_q.push_back(v);
				end
				1: begin
					repeat ($urandom_range(1, 10)) frame_q.push_back(8'($urandom));
				end
				2: begin
					repeat ($urandom_range(1, 8))
						frame_q.push_back(8'($urandom_range(0, 2) * 8'h55));
				end
				default: begin
					repeat ($urandom_range(2, 4)) frame_q.push_back(v);
					frame_q.push_back(~v);
				end
			endcase
		end
	endtask

	initial begin : stimulus
		int         n_rand;
		int         waited;
		logic [7:0] v;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		idle_on = 1'b1;

		foreach (dir_rows[i])
			send_item(dir_rows[i].data, dir_rows[i].eof, dir_rows[i].known,
				dir_rows[i].word, dir_rows[i].count);

		// run past the 130 limit
		v = 8'($urandom);
		frame_q.delete();
		repeat (131) frame_q.push_back(v);
		frame_q.push_back(v ^ 8'h01);
		frame_q.push_back(v);
		send_frame();

		// literal that overflows the store by one byte while the receiver holds off;
		// the flush backs up into the queue and the input stalls
		hold_start = 1'b1;
		idle_on = 1'b0;
		v = 8'($urandom);
		frame_q.delete();
		for (int i = 0; i < LITERAL_MAX + 1; i++)
			frame_q.push_back(8'(v + i));
		send_frame();
		idle_on = 1'b1;

		n_rand = 0;
		while (n_rand < RANDOM_ITEMS) begin
			if (n_rand >= RANDOM_ITEMS * 3 / 4)
				idle_on = 1'b0;
			build_random_frame();
			send_frame();
			n_rand += frame_q.size();
		end
		s_axis_tvalid <= 1'b0;
		idle_on = 1'b0;

		waited = 0;
		while (pending_words.size() != 0 && waited < 50000) begin
			@(posedge clk);
			waited++;
		end
		if (pending_words.size() != 0) begin
			$display("%0t: %0d expected words never arrived", $time, pending_words.size());
			errors++;
		end
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// receiver ready: random stalls, one long hold-off on request
	initial begin : sink_ready
		forever begin
			@(posedge clk);
			if (hold_start) begin
				hold_start = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				m_axis_tready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// compare each output transaction with the oldest expected word
	always @(posedge clk) begin : word_check
		enc_word_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected word %h count %0d last %0b", $time,
					m_axis_tdata, m_axis_tuser, m_axis_tlast);
				errors++;
			end else begin
				want = pending_words.pop_front();
				if (m_axis_tdata !== want.word) begin
					$display("%0t: word expected %h actual %h", $time, want.word, m_axis_tdata);
					errors++;
				end
				if (m_axis_tuser !== want.count) begin
					$display("%0t: count expected %0d actual %0d", $time, want.count,
						m_axis_tuser);
					errors++;
				end
				if (m_axis_tlast !== want.last) begin
					$display("%0t: last expected %0b actual %0b", $time, want.last,
						m_axis_tlast);
					errors++;
				end
			end
		end
	end

	initial begin : watchdog
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
